@@ rtl/bsc_pkg.sv @@
// Shared types, codes and default sizes for the safety check block.
`default_nettype none

package bsc_pkg;

   localparam int DEF_MAX_PROCS  = 16;
   localparam int DEF_MAX_RES    = 8;
   localparam int DEF_VALUE_BITS = 16;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_PROCS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_RES   = 2'd1;

   localparam logic [4:0] NUM_PROCS_RESET = 5'd16;
   localparam logic [3:0] NUM_RES_RESET   = 4'd8;

   localparam logic [1:0] FUNC_LOAD_CELL  = 2'd0;
   localparam logic [1:0] FUNC_LOAD_AVAIL = 2'd1;
   localparam logic [1:0] FUNC_CHECK      = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [3:0]  proc_index;
      logic [2:0]  res_index;
      logic [15:0] alloc_value;
      logic [15:0] max_value;
      logic [15:0] avail_value;
   } req_type;

   typedef struct packed {
      logic       safe;
      logic       has_process;
      logic [3:0] process_id;
      logic       last;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/bsc_ram.sv @@
// Single write port memory with one registered read port.
`default_nettype none

module bsc_ram import bsc_pkg::*; #(
   parameter int DEPTH = DEF_MAX_PROCS * DEF_MAX_RES,
   parameter int WIDTH = 2 * DEF_VALUE_BITS
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/bsc_alu.sv @@
// Shared need-versus-work compare and work accumulate unit.
`default_nettype none

module bsc_alu import bsc_pkg::*; #(
   parameter int VALUE_BITS = DEF_VALUE_BITS,
   parameter int WORK_BITS  = DEF_VALUE_BITS + 5
) (
   input  wire logic [VALUE_BITS-1:0] alloc_value,
   input  wire logic [VALUE_BITS-1:0] max_value,
   input  wire logic [WORK_BITS-1:0]  work_value,
   output logic                       fits,
   output logic      [WORK_BITS-1:0]  work_sum
);

   logic [VALUE_BITS:0] need;

   // A negative need always fits.
   assign need     = {1'b0, max_value} - {1'b0, alloc_value};
   assign fits     = need[VALUE_BITS] |
                     (WORK_BITS'(need[VALUE_BITS-1:0]) <= work_value);
   assign work_sum = work_value + WORK_BITS'(alloc_value);

endmodule

`default_nettype wire

@@ rtl/bankers_safety_check.sv @@
// Top level of the safety check: load decode, pass sequencer and result output.
//
//   Channel | Direction | Handshake          | Beat
//   req     | in        | req_valid/req_stall | req_data (req_type)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_data (rsp_type)
//   csr     | in        | csr_wr_en           | csr_index, csr_wdata
//
// A load beat is taken only while idle. A check scans each unfinished process resource by
// resource and adds a finishing one's allocation to the work vector; the end of each pass and
// each finished process skipped take a PICK step, and each safe result passes OUT_RD then OUT_LD.
// Reset clears the control state and the work vector; the matrices need no clearing.
// req_stall is high for the whole check; rsp_stall holds the output register and the output states.
`default_nettype none

module bankers_safety_check import bsc_pkg::*; #(
   parameter int MAX_PROCS  = DEF_MAX_PROCS,
   parameter int MAX_RES    = DEF_MAX_RES,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire req_type                   req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output rsp_type                        rsp_data,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int VB     = VALUE_BITS;
   localparam int PCW    = $clog2(MAX_PROCS + 1);
   localparam int RCW    = $clog2(MAX_RES + 1);
   localparam int PIW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int RIW    = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
   localparam int WB     = VB + PCW;
   localparam int MDEPTH = MAX_PROCS * MAX_RES;
   localparam int MAW    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PICK   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_ADD    = 3'd3;
   localparam logic [2:0] ST_OUT_RD = 3'd4;
   localparam logic [2:0] ST_OUT_LD = 3'd5;
   localparam logic [2:0] ST_UNSAFE = 3'd6;

   logic [2:0]     state_ff, state_in;
   logic [4:0]     num_procs_ff, num_procs_in;
   logic [3:0]     num_res_ff, num_res_in;
   logic [PCW-1:0] p_ff, p_in;
   logic [PCW-1:0] done_ff, done_in;
   logic [PCW-1:0] k_ff, k_in;
   logic [RIW-1:0] r_ff, r_in;
   logic           issue_ff, issue_in;
   logic           cmp_valid_ff, cmp_valid_in;
   logic [RIW-1:0] cmp_r_ff, cmp_r_in;
   logic           cmp_last_ff, cmp_last_in;
   logic           ok_ff, ok_in;
   logic           any_ff, any_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;
   logic [VB-1:0]  avail_ff [MAX_RES];
   logic [VB-1:0]  avail_in [MAX_RES];
   logic [WB-1:0]  work_ff [MAX_RES];
   logic [WB-1:0]  work_in [MAX_RES];
   logic [MAX_PROCS-1:0] fin_ff, fin_in;

   logic [PCW-1:0]  np;
   logic [RCW-1:0]  nr;
   logic            r_last;
   logic            req_accept;
   logic            can_load;
   logic            ok_next;
   logic            cell_ok;
   logic            avail_ok;
   logic            mat_wr_en;
   logic [MAW-1:0]  mat_wr_addr;
   logic [MAW-1:0]  mat_rd_addr;
   logic [2*VB-1:0] mat_wr_data;
   logic [2*VB-1:0] mat_rd_data;
   logic            seq_wr_en;
   logic [3:0]      seq_rd_data;
   logic            alu_fits;
   logic [WB-1:0]   alu_sum;

   always_comb begin
      if (num_procs_ff == '0) begin
         np = PCW'(1);
      end else if (32'(num_procs_ff) > 32'(MAX_PROCS)) begin
         np = PCW'(MAX_PROCS);
      end else begin
         np = PCW'(num_procs_ff);
      end
      if (num_res_ff == '0) begin
         nr = RCW'(1);
      end else if (32'(num_res_ff) > 32'(MAX_RES)) begin
         nr = RCW'(MAX_RES);
      end else begin
         nr = RCW'(num_res_ff);
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign can_load   = ~rsp_valid_ff | ~rsp_stall;
   assign r_last     = ((RCW'(r_ff) + RCW'(1)) == nr);
   assign cell_ok    = (32'(req_data.proc_index) < 32'(MAX_PROCS)) &&
                       (32'(req_data.res_index) < 32'(MAX_RES));
   assign avail_ok   = (32'(req_data.res_index) < 32'(MAX_RES));

   assign mat_wr_addr = MAW'(32'(req_data.proc_index) * 32'(MAX_RES) +
                             32'(req_data.res_index));
   assign mat_wr_data = {VB'(req_data.max_value), VB'(req_data.alloc_value)};
   assign mat_rd_addr = MAW'(32'(p_ff[PIW-1:0]) * 32'(MAX_RES) + 32'(r_ff));
   assign ok_next     = ok_ff & alu_fits;

   bsc_ram #(
      .DEPTH (MDEPTH),
      .WIDTH (2 * VB)
   ) u_matrix (
      .clock   (clock),
      .wr_en   (mat_wr_en),
      .wr_addr (mat_wr_addr),
      .wr_data (mat_wr_data),
      .rd_addr (mat_rd_addr),
      .rd_data (mat_rd_data)
   );

   bsc_ram #(
      .DEPTH (MAX_PROCS),
      .WIDTH (4)
   ) u_sequence (
      .clock   (clock),
      .wr_en   (seq_wr_en),
      .wr_addr (done_ff[PIW-1:0]),
      .wr_data (4'(p_ff)),
      .rd_addr (k_ff[PIW-1:0]),
      .rd_data (seq_rd_data)
   );

   bsc_alu #(
      .VALUE_BITS (VB),
      .WORK_BITS  (WB)
   ) u_alu (
      .alloc_value (mat_rd_data[VB-1:0]),
      .max_value   (mat_rd_data[2*VB-1:VB]),
      .work_value  (work_ff[cmp_r_ff]),
      .fits        (alu_fits),
      .work_sum    (alu_sum)
   );

   always_comb begin
      state_in     = state_ff;
      num_procs_in = num_procs_ff;
      num_res_in   = num_res_ff;
      p_in         = p_ff;
      done_in      = done_ff;
      k_in         = k_ff;
      r_in         = r_ff;
      issue_in     = issue_ff;
      cmp_valid_in = 1'b0;
      cmp_r_in     = r_ff;
      cmp_last_in  = r_last;
      ok_in        = ok_ff;
      any_in       = any_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      avail_in     = avail_ff;
      work_in      = work_ff;
      fin_in       = fin_ff;
      mat_wr_en    = 1'b0;
      seq_wr_en    = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NUM_PROCS: num_procs_in = csr_wdata[4:0];
            CSR_NUM_RES:   num_res_in   = csr_wdata[3:0];
            default: ;
         endcase
      end

      if (issue_ff) begin
         cmp_valid_in = 1'b1;
         if (r_last) begin
            issue_in = 1'b0;
         end else begin
            r_in = r_ff + RIW'(1);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_data.func)
                  FUNC_LOAD_CELL: begin
                     mat_wr_en = cell_ok;
                  end
                  FUNC_LOAD_AVAIL: begin
                     if (avail_ok) begin
                        avail_in[RIW'(req_data.res_index)] = VB'(req_data.avail_value);
                     end
                  end
                  FUNC_CHECK: begin
                     for (int i = 0; i < MAX_RES; i++) begin
                        work_in[i] = (i < int'(nr)) ? WB'(avail_ff[i]) : '0;
                     end
                     fin_in   = '0;
                     done_in  = '0;
                     p_in     = '0;
                     any_in   = 1'b0;
                     state_in = ST_PICK;
                  end
                  default: ;
               endcase
            end
         end
         ST_PICK: begin
            if (done_ff == np) begin
               k_in     = '0;
               state_in = ST_OUT_RD;
            end else if (p_ff == np) begin
               if (!any_ff) begin
                  state_in = ST_UNSAFE;
               end else begin
                  p_in   = '0;
                  any_in = 1'b0;
               end
            end else if (fin_ff[p_ff[PIW-1:0]]) begin
               p_in = p_ff + PCW'(1);
            end else begin
               r_in     = '0;
               issue_in = 1'b1;
               ok_in    = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cmp_valid_ff) begin
               ok_in = ok_next;
               if (cmp_last_ff) begin
                  if (ok_next) begin
                     r_in     = '0;
                     issue_in = 1'b1;
                     state_in = ST_ADD;
                  end else begin
                     p_in     = p_ff + PCW'(1);
                     state_in = ST_PICK;
                  end
               end
            end
         end
         ST_ADD: begin
            if (cmp_valid_ff) begin
               work_in[cmp_r_ff] = alu_sum;
               if (cmp_last_ff) begin
                  fin_in[p_ff[PIW-1:0]] = 1'b1;
                  seq_wr_en = 1'b1;
                  done_in   = done_ff + PCW'(1);
                  any_in    = 1'b1;
                  p_in      = p_ff + PCW'(1);
                  state_in  = ST_PICK;
               end
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            if (can_load) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.safe        = 1'b1;
               rsp_data_in.has_process = 1'b1;
               rsp_data_in.process_id  = seq_rd_data;
               rsp_data_in.last        = ((k_ff + PCW'(1)) == done_ff);
               if ((k_ff + PCW'(1)) == done_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + PCW'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         ST_UNSAFE: begin
            if (can_load) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.safe        = 1'b0;
               rsp_data_in.has_process = 1'b0;
               rsp_data_in.process_id  = '0;
               rsp_data_in.last        = 1'b1;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         num_procs_ff <= NUM_PROCS_RESET;
         num_res_ff   <= NUM_RES_RESET;
         issue_ff     <= 1'b0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fin_ff       <= '0;
         for (int i = 0; i < MAX_RES; i++) begin
            work_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         num_procs_ff <= num_procs_in;
         num_res_ff   <= num_res_in;
         issue_ff     <= issue_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fin_ff       <= fin_in;
         work_ff      <= work_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      done_ff     <= done_in;
      k_ff        <= k_in;
      r_ff        <= r_in;
      cmp_r_ff    <= cmp_r_in;
      cmp_last_ff <= cmp_last_in;
      ok_ff       <= ok_in;
      any_ff      <= any_in;
      rsp_data_ff <= rsp_data_in;
      avail_ff    <= avail_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
